// ===== src/rgb2yuv_pkg.sv =====
// Shared types, sizes and color weights for the RGB to YUV 4:2:0 converter.
// No dependencies; the other files, apart from rgb2yuv_ram, refer to it by scoped names.
`default_nettype none

package rgb2yuv_pkg;

	// Frame geometry
	localparam int MAX_WIDTH   = 2048;
	localparam int STORE_DEPTH = MAX_WIDTH / 2;
	localparam int CFG_W       = 12;
	localparam int COL_W       = $clog2(MAX_WIDTH);
	localparam int ROW_W       = CFG_W;
	localparam int IDX_W       = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int WID_W       = (CFG_W > COL_W) ? CFG_W : COL_W + 1;

	// Configuration register indexes
	localparam int                  REG_IDX_W        = 2;
	localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

	localparam logic [CFG_W-1:0] WIDTH_RESET  = 12'd640;
	localparam logic [CFG_W-1:0] HEIGHT_RESET = 12'd480;

	// Weight magnitudes; signs are applied in the sums
	localparam int WGT_W  = 15;
	localparam int PROD_W = 23;
	localparam int SUM_W  = 25;

	localparam logic [WGT_W-1:0] K_Y_R = 15'd9796;
	localparam logic [WGT_W-1:0] K_Y_G = 15'd19235;
	localparam logic [WGT_W-1:0] K_Y_B = 15'd3736;
	localparam logic [WGT_W-1:0] K_U_R = 15'd4784;   // negative
	localparam logic [WGT_W-1:0] K_U_G = 15'd9437;   // negative
	localparam logic [WGT_W-1:0] K_U_B = 15'd14221;
	localparam logic [WGT_W-1:0] K_V_R = 15'd20218;
	localparam logic [WGT_W-1:0] K_V_G = 15'd16941;  // negative
	localparam logic [WGT_W-1:0] K_V_B = 15'd3277;   // negative

	localparam int         LUMA_SHIFT   = 15;
	localparam int         CHROMA_SHIFT = 17;
	localparam logic [7:0] CHROMA_OFS   = 8'd32;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pix_t;

	typedef struct packed {
		logic [7:0] luma;
		logic       chroma_valid;
		logic [7:0] chroma_u;
		logic [7:0] chroma_v;
		logic       frame_last;
	} yuv_t;

	// Position of an item in the frame, carried down the pipeline
	typedef struct packed {
		logic             odd_row;
		logic             odd_col;
		logic [IDX_W-1:0] idx;
		logic             last;
	} pos_t;

	// Stage advance enables and occupancy shared by the datapath modules
	typedef struct packed {
		logic adv_s1;
		logic adv_s2;
		logic adv_s3;
		logic adv_out;
		logic vld_s2;
		logic vld_s3;
	} stage_ctl_t;

	function automatic logic [PROD_W-1:0] cmul(logic [7:0] x, logic [WGT_W-1:0] k);
		return PROD_W'(x) * PROD_W'(k);
	endfunction

endpackage

`default_nettype wire

// ===== src/rgb2yuv_pix_if.sv =====
// Input pixel channel: valid/ready handshake with one RGB item.
// Depends on rgb2yuv_pkg.
`default_nettype none

interface rgb2yuv_pix_if;
	logic                valid;
	logic                ready;
	rgb2yuv_pkg::pix_t   data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== src/rgb2yuv_yuv_if.sv =====
// Output channel: valid/ready handshake with one Y/U/V item.
// Depends on rgb2yuv_pkg.
`default_nettype none

interface rgb2yuv_yuv_if;
	logic                valid;
	logic                ready;
	rgb2yuv_pkg::yuv_t   data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== src/rgb2yuv_cfg_if.sv =====
// Configuration write channel: register index and write data.
// Depends on rgb2yuv_pkg.
`default_nettype none

interface rgb2yuv_cfg_if;
	logic                                  valid;
	logic                                  ready;
	logic [rgb2yuv_pkg::REG_IDX_W-1:0]     index;
	logic [rgb2yuv_pkg::CFG_W-1:0]         data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== src/rgb2yuv_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// A read at the address being written returns the old contents.
`default_nettype none

module rgb2yuv_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  wire logic                                 clk,
	input  wire logic                                 wr_en,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]                     wr_data,
	input  wire logic                                 rd_en,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic      [WIDTH-1:0]                     rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== src/rgb2yuv_color.sv =====
// Color math pipeline: input register, weighted products, then luma and
// the per-pixel U/V terms. Depends on rgb2yuv_pkg.
`default_nettype none

module rgb2yuv_color (
	input  wire logic                    clk,
	input  wire rgb2yuv_pkg::stage_ctl_t stg,
	input  wire rgb2yuv_pkg::pix_t       pix_in,
	output logic [7:0]                   luma_s3,
	output logic [7:0]                   tu_s3,
	output logic [7:0]                   tv_s3
);

	rgb2yuv_pkg::pix_t pix_s1;

	logic [rgb2yuv_pkg::PROD_W-1:0] py_r_s2, py_g_s2, py_b_s2;
	logic [rgb2yuv_pkg::PROD_W-1:0] pu_r_s2, pu_g_s2, pu_b_s2;
	logic [rgb2yuv_pkg::PROD_W-1:0] pv_r_s2, pv_g_s2, pv_b_s2;

	logic [rgb2yuv_pkg::PROD_W-1:0] y_sum;
	logic [rgb2yuv_pkg::SUM_W-1:0]  u_sum;
	logic [rgb2yuv_pkg::SUM_W-1:0]  v_sum;

	always_ff @(posedge clk) begin
		if (stg.adv_s1) begin
			pix_s1 <= pix_in;
		end
	end

	always_ff @(posedge clk) begin
		if (stg.adv_s2) begin
			py_r_s2 <= rgb2yuv_pkg::cmul(pix_s1.red,   rgb2yuv_pkg::K_Y_R);
			py_g_s2 <= rgb2yuv_pkg::cmul(pix_s1.green, rgb2yuv_pkg::K_Y_G);
			py_b_s2 <= rgb2yuv_pkg::cmul(pix_s1.blue,  rgb2yuv_pkg::K_Y_B);
			pu_r_s2 <= rgb2yuv_pkg::cmul(pix_s1.red,   rgb2yuv_pkg::K_U_R);
			pu_g_s2 <= rgb2yuv_pkg::cmul(pix_s1.green, rgb2yuv_pkg::K_U_G);
			pu_b_s2 <= rgb2yuv_pkg::cmul(pix_s1.blue,  rgb2yuv_pkg::K_U_B);
			pv_r_s2 <= rgb2yuv_pkg::cmul(pix_s1.red,   rgb2yuv_pkg::K_V_R);
			pv_g_s2 <= rgb2yuv_pkg::cmul(pix_s1.green, rgb2yuv_pkg::K_V_G);
			pv_b_s2 <= rgb2yuv_pkg::cmul(pix_s1.blue,  rgb2yuv_pkg::K_V_B);
		end
	end

	// Sums wrap in two's complement; the chroma window is floor(x / 2^17) mod 256
	always_comb begin
		y_sum = py_r_s2 + py_g_s2 + py_b_s2;
		u_sum = rgb2yuv_pkg::SUM_W'(pu_b_s2) - rgb2yuv_pkg::SUM_W'(pu_r_s2)
			- rgb2yuv_pkg::SUM_W'(pu_g_s2);
		v_sum = rgb2yuv_pkg::SUM_W'(pv_r_s2) - rgb2yuv_pkg::SUM_W'(pv_g_s2)
			- rgb2yuv_pkg::SUM_W'(pv_b_s2);
	end

	always_ff @(posedge clk) begin
		if (stg.adv_s3) begin
			luma_s3 <= y_sum[rgb2yuv_pkg::LUMA_SHIFT +: 8];
			tu_s3   <= u_sum[rgb2yuv_pkg::CHROMA_SHIFT +: 8] + rgb2yuv_pkg::CHROMA_OFS;
			tv_s3   <= v_sum[rgb2yuv_pkg::CHROMA_SHIFT +: 8] + rgb2yuv_pkg::CHROMA_OFS;
		end
	end

endmodule

`default_nettype wire

// ===== src/rgb2yuv_chroma.sv =====
// Chroma accumulation: line store read-modify-write, pair partial sums,
// forwarding and the output register. Depends on rgb2yuv_pkg, rgb2yuv_ram.
`default_nettype none

module rgb2yuv_chroma (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire rgb2yuv_pkg::stage_ctl_t stg,
	input  wire rgb2yuv_pkg::pos_t       pos_s2,
	input  wire rgb2yuv_pkg::pos_t       pos_s3,
	input  wire logic [7:0]              luma_s3,
	input  wire logic [7:0]              tu_s3,
	input  wire logic [7:0]              tv_s3,
	output rgb2yuv_pkg::yuv_t            out_q
);

	logic                               rd_en;
	logic                               wr_en;
	logic [15:0]                        rd_data;
	logic [15:0]                        wr_data;
	logic                               fwd_q;
	logic [15:0]                        fwd_data_q;
	logic [7:0]                         pair_u_q;
	logic [7:0]                         pair_v_q;
	logic [15:0]                        line_data;
	logic [7:0]                         base_u;
	logic [7:0]                         base_v;
	logic [7:0]                         sum_u;
	logic [7:0]                         sum_v;
	logic                               finish;

	// Read the line store as an item enters s3; write as an even-row pair closes
	assign rd_en   = stg.adv_s3 && stg.vld_s2;
	assign wr_en   = stg.adv_out && stg.vld_s3 && !pos_s3.odd_row && pos_s3.odd_col;
	assign wr_data = {sum_u, sum_v};

	rgb2yuv_ram #(
		.WIDTH(16),
		.DEPTH(rgb2yuv_pkg::STORE_DEPTH)
	) u_line_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (pos_s3.idx),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (pos_s2.idx),
		.rd_data (rd_data)
	);

	// Capture a write that lands on the entry being read in the same cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else if (rd_en) begin
			fwd_q <= wr_en && (pos_s3.idx == pos_s2.idx);
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			fwd_data_q <= wr_data;
		end
	end

	always_comb begin
		line_data = fwd_q ? fwd_data_q : rd_data;
		base_u    = pos_s3.odd_row ? line_data[15:8] : 8'd0;
		base_v    = pos_s3.odd_row ? line_data[7:0]  : 8'd0;
		sum_u     = (pos_s3.odd_col ? pair_u_q : base_u) + tu_s3;
		sum_v     = (pos_s3.odd_col ? pair_v_q : base_v) + tv_s3;
		finish    = pos_s3.odd_row && pos_s3.odd_col;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_u_q <= 8'd0;
			pair_v_q <= 8'd0;
		end else if (stg.adv_out && stg.vld_s3 && !pos_s3.odd_col) begin
			pair_u_q <= sum_u;
			pair_v_q <= sum_v;
		end
	end

	always_ff @(posedge clk) begin
		if (stg.adv_out) begin
			out_q.luma         <= luma_s3;
			out_q.chroma_valid <= finish;
			out_q.chroma_u     <= finish ? sum_u : 8'd0;
			out_q.chroma_v     <= finish ? sum_v : 8'd0;
			out_q.frame_last   <= pos_s3.last;
		end
	end

endmodule

`default_nettype wire

// ===== src/rgb24_to_yuv420_converter.sv =====
// Top level of the RGB to YUV 4:2:0 converter: counters, configuration,
// pipeline control. Depends on rgb2yuv_pkg, the channel interfaces,
// rgb2yuv_color and rgb2yuv_chroma.
//
// Usage:
//   pix carries one RGB pixel per item in raster order; yuv returns exactly
//   one item per pixel: its luma, and on the second pixel of each pair of an
//   odd row the finished U and V of the 2x2 block (chroma_valid high).
//   frame_last marks the last pixel of the frame.
//   cfg writes frame_width (index 0) and frame_height (index 1); it is
//   always ready. Write only while no pixel is in flight.
// Path: a pixel accepted into the input register moves through products and
//   terms to the output register, from which it is offered on yuv.
// Throughput: one pixel per cycle while yuv takes its items. The even-row
//   pair sums live in one 1024 x 16 line store with one write and one read
//   port; a read that meets a write to the same entry is forwarded.
// Reset: size registers return to 640 x 480, counters and pair sums clear,
//   the pipeline empties. The line store is not cleared.
// Stall: when yuv is not taken the output register holds; empty stages
//   still fill, and pix.ready drops only once all four stages hold items.
`default_nettype none

module rgb24_to_yuv420_converter (
	input wire logic          clk,
	input wire logic          arst_n,
	rgb2yuv_pix_if.sink       pix,
	rgb2yuv_yuv_if.source     yuv,
	rgb2yuv_cfg_if.sink       cfg
);

	// Configuration registers
	logic [rgb2yuv_pkg::CFG_W-1:0] width_q;
	logic [rgb2yuv_pkg::CFG_W-1:0] height_q;

	// Raster position of the next accepted pixel
	logic [rgb2yuv_pkg::COL_W-1:0] col_q;
	logic [rgb2yuv_pkg::ROW_W-1:0] row_q;

	logic [rgb2yuv_pkg::CFG_W-1:0] w_even;
	logic [rgb2yuv_pkg::WID_W-1:0] w_eff;
	logic [rgb2yuv_pkg::CFG_W-1:0] h_even;
	logic [rgb2yuv_pkg::CFG_W-1:0] h_eff;
	logic                          col_wrap;
	logic                          row_wrap;
	logic                          accept;

	// Pipeline occupancy and positions
	logic                          s1_valid_q;
	logic                          s2_valid_q;
	logic                          s3_valid_q;
	logic                          out_valid_q;
	rgb2yuv_pkg::pos_t             pos_in;
	rgb2yuv_pkg::pos_t             pos_s1;
	rgb2yuv_pkg::pos_t             pos_s2;
	rgb2yuv_pkg::pos_t             pos_s3;
	rgb2yuv_pkg::stage_ctl_t       stg;

	logic [7:0]                    luma_s3;
	logic [7:0]                    tu_s3;
	logic [7:0]                    tv_s3;
	rgb2yuv_pkg::yuv_t             out_q;

	// Configuration: always ready, ignore indexes beyond the list
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= rgb2yuv_pkg::WIDTH_RESET;
			height_q <= rgb2yuv_pkg::HEIGHT_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				rgb2yuv_pkg::REG_FRAME_WIDTH:  width_q  <= cfg.data;
				rgb2yuv_pkg::REG_FRAME_HEIGHT: height_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// Effective size: drop bit 0, clamp width to 2..MAX_WIDTH, height to 2 and up
	always_comb begin
		w_even = {width_q[rgb2yuv_pkg::CFG_W-1:1], 1'b0};
		h_even = {height_q[rgb2yuv_pkg::CFG_W-1:1], 1'b0};
		if (w_even < rgb2yuv_pkg::CFG_W'(2)) begin
			w_eff = rgb2yuv_pkg::WID_W'(2);
		end else if (rgb2yuv_pkg::WID_W'(w_even) > rgb2yuv_pkg::WID_W'(rgb2yuv_pkg::MAX_WIDTH)) begin
			w_eff = rgb2yuv_pkg::WID_W'(rgb2yuv_pkg::MAX_WIDTH);
		end else begin
			w_eff = rgb2yuv_pkg::WID_W'(w_even);
		end
		h_eff = (h_even < rgb2yuv_pkg::CFG_W'(2)) ? rgb2yuv_pkg::CFG_W'(2) : h_even;

		// A counter at or past the last position wraps as if it were the last
		col_wrap = (rgb2yuv_pkg::WID_W'(col_q) + rgb2yuv_pkg::WID_W'(1)) >= w_eff;
		row_wrap = ({1'b0, row_q} + (rgb2yuv_pkg::ROW_W + 1)'(1)) >= {1'b0, h_eff};

		pos_in.odd_row = row_q[0];
		pos_in.odd_col = col_q[0];
		pos_in.idx     = rgb2yuv_pkg::IDX_W'(col_q >> 1);
		pos_in.last    = col_wrap && row_wrap;
	end

	// Stage advance: a stage moves when the one after it is empty or moving
	always_comb begin
		stg.adv_out = !out_valid_q || yuv.ready;
		stg.adv_s3  = !s3_valid_q || stg.adv_out;
		stg.adv_s2  = !s2_valid_q || stg.adv_s3;
		stg.adv_s1  = !s1_valid_q || stg.adv_s2;
		stg.vld_s2  = s2_valid_q;
		stg.vld_s3  = s3_valid_q;
	end

	assign pix.ready = stg.adv_s1;
	assign accept    = pix.valid && stg.adv_s1;

	// Advance the raster counters on every accepted pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (col_wrap) begin
				col_q <= '0;
				row_q <= row_wrap ? '0 : row_q + rgb2yuv_pkg::ROW_W'(1);
			end else begin
				col_q <= col_q + rgb2yuv_pkg::COL_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			s2_valid_q  <= 1'b0;
			s3_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (stg.adv_s1) begin
				s1_valid_q <= pix.valid;
			end
			if (stg.adv_s2) begin
				s2_valid_q <= s1_valid_q;
			end
			if (stg.adv_s3) begin
				s3_valid_q <= s2_valid_q;
			end
			if (stg.adv_out) begin
				out_valid_q <= s3_valid_q;
			end
		end
	end

	// Carry each item's frame position alongside its color data
	always_ff @(posedge clk) begin
		if (stg.adv_s1) begin
			pos_s1 <= pos_in;
		end
		if (stg.adv_s2) begin
			pos_s2 <= pos_s1;
		end
		if (stg.adv_s3) begin
			pos_s3 <= pos_s2;
		end
	end

	rgb2yuv_color u_color (
		.clk     (clk),
		.stg     (stg),
		.pix_in  (pix.data),
		.luma_s3 (luma_s3),
		.tu_s3   (tu_s3),
		.tv_s3   (tv_s3)
	);

	rgb2yuv_chroma u_chroma (
		.clk     (clk),
		.arst_n  (arst_n),
		.stg     (stg),
		.pos_s2  (pos_s2),
		.pos_s3  (pos_s3),
		.luma_s3 (luma_s3),
		.tu_s3   (tu_s3),
		.tv_s3   (tv_s3),
		.out_q   (out_q)
	);

	assign yuv.valid = out_valid_q;
	assign yuv.data  = out_q;

	// Input stalls only when every stage is occupied and the output is blocked
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!pix.ready |-> (s1_valid_q && s2_valid_q && s3_valid_q && out_valid_q && !yuv.ready))
		else $error("input stalled with room in the pipeline");

	// Closing pixel of an odd-row pair comes out with finished chroma
	a_chroma_on_close: assert property (@(posedge clk) disable iff (!arst_n)
		(stg.adv_out && s3_valid_q && pos_s3.odd_row && pos_s3.odd_col)
		|=> (yuv.valid && yuv.data.chroma_valid))
		else $error("finished block not flagged");

	// The last pixel of a frame restarts the raster at the origin
	a_frame_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && pos_in.last) |=> (col_q == '0 && row_q == '0))
		else $error("counters did not wrap at frame end");

	// Output chroma fields are zero unless a block is finished
	a_chroma_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(yuv.valid && !yuv.data.chroma_valid)
		|-> (yuv.data.chroma_u == 8'd0 && yuv.data.chroma_v == 8'd0))
		else $error("chroma fields set without a finished block");

endmodule

`default_nettype wire
